// File: hdl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants of the signed varint decoder
// Field widths of the decoded result and the state of the byte framer.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int BYTE_W = 8;
    localparam int MAG_W  = 60;
    localparam int VAL_W  = 61;
    localparam int LEN_W  = 4;
    localparam int CNT_W  = 3;

    // head byte layout
    localparam int HEAD_CNT_LSB = 5;
    localparam int HEAD_SIGN    = 4;
    localparam int HEAD_NIB_W   = 4;

    // first follower lands at this magnitude bit
    localparam logic [5:0] FOLLOW_BASE = 6'd4;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        length;
    } result_t;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] data;
    } step_req_t;

endpackage

// File: hdl/vsd_decode.sv
// ----------------------------------------------------------------------------
// vsd_decode: framing state and single-pass decode of one byte
// Holds the collecting state and the magnitude gathered so far; gives the
// completed integer combinationally for the byte being retired.
// ----------------------------------------------------------------------------
module vsd_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  vsd_pkg::step_req_t  req,
    output logic                emit,
    output vsd_pkg::result_t    result
);

    logic                          collecting_reg, collecting_next;
    logic [vsd_pkg::CNT_W-1:0]     followers_left_reg, followers_left_next;
    logic [vsd_pkg::CNT_W-1:0]     follower_total_reg, follower_total_next;
    logic [vsd_pkg::MAG_W-1:0]     magnitude_reg, magnitude_next;
    logic                          negative_reg, negative_next;
    logic [vsd_pkg::CNT_W-1:0]     position_reg, position_next;

    logic [vsd_pkg::BYTE_W-1:0]    b;
    logic [vsd_pkg::CNT_W-1:0]     head_cnt;
    logic [5:0]                    shamt;
    logic [vsd_pkg::MAG_W-1:0]     follow_bits;
    logic [vsd_pkg::VAL_W-1:0]     mag_ext;
    logic                          short_form;

    assign b           = req.data;
    assign head_cnt    = b[vsd_pkg::HEAD_CNT_LSB +: vsd_pkg::CNT_W];
    assign shamt       = {position_reg, 3'b000} + vsd_pkg::FOLLOW_BASE;
    // bits shifted past the magnitude width drop out here
    assign follow_bits = {{(vsd_pkg::MAG_W-vsd_pkg::BYTE_W){1'b0}}, b} << shamt;
    assign short_form  = !collecting_reg && (b[7:4] == 4'd0);

    always_comb
    begin
        collecting_next     = collecting_reg;
        followers_left_next = followers_left_reg;
        follower_total_next = follower_total_reg;
        magnitude_next      = magnitude_reg;
        negative_next       = negative_reg;
        position_next       = position_reg;
        emit                = 1'b0;

        if (req.fire)
        begin
            if (!collecting_reg)
            begin
                if (short_form)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    follower_total_next = head_cnt;
                    followers_left_next = head_cnt;
                    negative_next       = b[vsd_pkg::HEAD_SIGN];
                    magnitude_next      = {{(vsd_pkg::MAG_W-vsd_pkg::HEAD_NIB_W){1'b0}},
                                           b[vsd_pkg::HEAD_NIB_W-1:0]};
                    position_next       = '0;
                    if (head_cnt == '0)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        collecting_next = 1'b1;
                    end
                end
            end
            else
            begin
                magnitude_next      = magnitude_reg | follow_bits;
                position_next       = position_reg + 3'd1;
                followers_left_next = followers_left_reg - 3'd1;
                if (followers_left_next == '0)
                begin
                    collecting_next = 1'b0;
                    emit            = 1'b1;
                end
            end
        end

        mag_ext       = {1'b0, magnitude_next};
        result.value  = negative_next ? (-mag_ext) : mag_ext;
        result.length = {1'b0, follower_total_next} + 4'd1;
        if (short_form)
        begin
            // short form: value is the byte itself
            result.value  = {{(vsd_pkg::VAL_W-vsd_pkg::BYTE_W){1'b0}}, b};
            result.length = 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg     <= 1'b0;
            followers_left_reg <= '0;
            follower_total_reg <= '0;
            magnitude_reg      <= '0;
            negative_reg       <= 1'b0;
            position_reg       <= '0;
        end
        else
        begin
            collecting_reg     <= collecting_next;
            followers_left_reg <= followers_left_next;
            follower_total_reg <= follower_total_next;
            magnitude_reg      <= magnitude_next;
            negative_reg       <= negative_next;
            position_reg       <= position_next;
        end
    end

endmodule

// File: hdl/varint_signed_decoder_core.sv
// ----------------------------------------------------------------------------
// varint_signed_decoder_core: sign-magnitude varint stream decoder
// Rebuilds signed integers from a byte stream of head and follower bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stream byte per request. A head byte gives the
//   follower count (bits 7:5), the sign (bit 4) and the low magnitude
//   nibble; followers add eight magnitude bits each, least significant first.
//   m_axis carries one request per completed integer: the signed value and
//   the number of bytes it used.
//   Throughput is one byte per cycle while the receiver does not stall. A byte
//   passes an input register and is then decoded into the result register,
//   so the integer completed by a byte shows on m_axis once the result
//   register holds it.
//   Bytes that complete nothing leave no output request.
//   Reset clears the framing state: the first byte after reset is a head.
//   When the receiver stalls, the result register holds its request and the
//   input register still takes one more byte; s_axis_tready then drops
//   until m_axis_tready returns.
// ----------------------------------------------------------------------------
module varint_signed_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [60:0] decoded_value, [64:61] byte_length
);

    logic                        byte_valid_reg, byte_valid_next;
    logic [vsd_pkg::BYTE_W-1:0]  byte_reg;
    logic                        res_valid_reg, res_valid_next;
    vsd_pkg::result_t            res_reg;
    logic                        res_free;
    logic                        fire;
    logic                        take_in;
    logic                        emit;
    vsd_pkg::result_t            result;
    vsd_pkg::step_req_t          req;

    assign res_free      = !res_valid_reg || m_axis_tready;
    assign fire          = byte_valid_reg && res_free;
    assign s_axis_tready = !byte_valid_reg || fire;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign req.fire = fire;
    assign req.data = byte_reg;

    vsd_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .emit   (emit),
        .result (result)
    );

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (take_in)
        begin
            byte_valid_next = 1'b1;
        end
        else if (fire)
        begin
            byte_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= s_axis_tdata;
        end
        if (fire && emit)
        begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.length, res_reg.value};

    // an empty input stage always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    // every delivered integer used one to eight bytes
    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res_reg.length != 4'd0) && (res_reg.length <= 4'd8))
        else $error("byte length out of range");

    // a taken result with nothing new decoded leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !(fire && emit)) |=> !m_axis_tvalid)
        else $error("result repeated after delivery");

endmodule

// File: tb/sv/varint_signed_decoder_core_test.sv
// ----------------------------------------------------------------------------
// varint_signed_decoder_core_test: stream test of the signed varint decoder
// Feeds well-formed integers, short forms and stray bytes through s_axis with
// random gaps and receiver stalls. A byte-level framer model predicts each
// decoded value and length, and every m_axis request is checked in order.
// ----------------------------------------------------------------------------

class varint_scoreboard;

    // framer state, mirrors the decoder
    bit                      collecting;
    bit [vsd_pkg::CNT_W-1:0] followers_left;
    bit [vsd_pkg::CNT_W-1:0] follower_total;
    bit [vsd_pkg::CNT_W-1:0] byte_position;
    bit [vsd_pkg::MAG_W-1:0] magnitude;
    bit                      negative;

    vsd_pkg::result_t        pending_ints[$];
    int                      errors;
    int                      ints_checked;
    bit [8:0]                lengths_seen;

    function vsd_pkg::result_t close_integer(bit [vsd_pkg::LEN_W-1:0] len);
        vsd_pkg::result_t        r;
        bit [vsd_pkg::VAL_W-1:0] mag_ext;
        mag_ext  = {1'b0, magnitude};
        r.value  = negative ? -mag_ext : mag_ext;
        r.length = len;
        return r;
    endfunction

    function void note_byte(bit [vsd_pkg::BYTE_W-1:0] b);
        vsd_pkg::result_t r;
        if (!collecting)
        begin
            if (b[7:4] == 4'd0)
            begin
                // short form: the byte is the value
                r.value  = vsd_pkg::VAL_W'(b);
                r.length = vsd_pkg::LEN_W'(1);
                pending_ints.push_back(r);
            end
            else
            begin
                follower_total = b[7:vsd_pkg::HEAD_CNT_LSB];
                followers_left = b[7:vsd_pkg::HEAD_CNT_LSB];
                negative       = b[vsd_pkg::HEAD_SIGN];
                magnitude      = vsd_pkg::MAG_W'(b[3:0]);
                byte_position  = '0;
                if (follower_total == 0)
                    pending_ints.push_back(close_integer(vsd_pkg::LEN_W'(1)));
                else
                    collecting = 1'b1;
            end
        end
        else
        begin
            magnitude      = magnitude |
                             (vsd_pkg::MAG_W'(b) << (4 + 8 * int'(byte_position)));
            byte_position  = byte_position + 1'b1;
            followers_left = followers_left - 1'b1;
            if (followers_left == 0)
            begin
                collecting = 1'b0;
                pending_ints.push_back(
                    close_integer(vsd_pkg::LEN_W'(follower_total) + 1'b1));
            end
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [71:0] word);
        vsd_pkg::result_t want;
        logic signed [vsd_pkg::VAL_W-1:0] got_value;
        logic [vsd_pkg::LEN_W-1:0]        got_length;
        got_value  = word[vsd_pkg::VAL_W-1:0];
        got_length = word[vsd_pkg::VAL_W +: vsd_pkg::LEN_W];
        if (pending_ints.size() == 0)
        begin
            report($sformatf("unexpected result value %0d length %0d",
                             got_value, got_length));
        end
        else
        begin
            want = pending_ints.pop_front();
            ints_checked++;
            if (got_length <= 8)
                lengths_seen[got_length] = 1'b1;
            if (got_value !== want.value)
                report($sformatf("integer %0d value %0d, expected %0d",
                                 ints_checked, got_value, want.value));
            if (got_length !== want.length)
                report($sformatf("integer %0d length %0d, expected %0d",
                                 ints_checked, got_length, want.length));
        end
    endtask

endclass

module varint_signed_decoder_core_test;

    localparam int RANDOM_BYTES = 2000;
    localparam int CALM_BYTES   = 300;
    localparam int QUIET_LIMIT  = 2000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;           // [60:0] decoded_value, [64:61] byte_length

    varint_scoreboard board = new();

    bit idle_on = 1'b1;
    int bytes_sent;
    int stall_left;

    varint_signed_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // entered and left at a falling edge
    task send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task send_int(input bit neg, input int cnt, input logic [3:0] nib,
                  input logic [55:0] follow);
        send_byte({cnt[2:0], neg, nib});
        for (int i = 0; i < cnt; i++)
            send_byte(follow[8*i +: 8]);
    endtask

    // hold the sender off until every decoded integer is back
    task drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending_ints.size() != 0)
            @(negedge clk);
    endtask

    // receiver with random stall bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // watchdog on cycles with no request moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("varint_signed_decoder_core_test: errors");
        $finish;
    end

    initial
    begin
        int          pick;
        int          cnt;
        int          stop_at;
        bit          paused;
        logic [55:0] follow;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short forms, signed zero, nibble extremes, widest integers
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'h10);
        send_byte(8'h1F);
        send_int(1'b1, 1, 4'h3, 56'h80);
        send_int(1'b1, 1, 4'h0, 56'h00);
        send_int(1'b0, 7, 4'hF, {56{1'b1}});
        send_int(1'b1, 7, 4'hF, {56{1'b1}});
        drain();

        stop_at = bytes_sent + RANDOM_BYTES;
        paused  = 1'b0;
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent > stop_at - CALM_BYTES)
                idle_on = 1'b0;
            if (!paused && bytes_sent > stop_at - RANDOM_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                cnt    = int'($urandom_range(0, 7));
                follow = 56'({$urandom, $urandom});
                case ($urandom_range(0, 9))
                    0: follow = '0;
                    1: follow = '1;
                    default: ;
                endcase
                send_int(1'($urandom_range(0, 1)), cnt, 4'($urandom_range(0, 15)),
                         follow);
            end
            else if (pick < 92)
                send_byte(8'($urandom_range(0, 15)));
            else
                // stray byte, knocks the framing off
                send_byte(8'($urandom_range(0, 255)));
        end

        drain();
        repeat (8) @(negedge clk);

        $display("run covered %0d stream bytes and %0d decoded integers",
                 bytes_sent, board.ints_checked);
        $display("byte lengths seen (bit n = length n): %b", board.lengths_seen[8:1]);
        if (board.errors == 0)
            $display("varint_signed_decoder_core_test: clean");
        else
            $display("varint_signed_decoder_core_test: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/vsd_pkg.sv
hdl/vsd_decode.sv
hdl/varint_signed_decoder_core.sv
tb/sv/varint_signed_decoder_core_test.sv
